@@ hdl/fcs_pkg.sv @@
// Package with types, widths and register indexes of the predictive switch selector.
package fcs_pkg;

   // Problem sizes.
   localparam int STATE_DIM  = 2;
   localparam int CANDIDATES = 8;
   localparam int LEGS       = 3;

   // Payload and arithmetic types.
   typedef logic signed [15:0] sample_type;    // Q4.12 state and reference
   typedef logic signed [17:0] coef_type;      // Q2.16 state matrix entry
   typedef logic signed [33:0] prod_type;      // Q6.28 product
   typedef logic signed [34:0] psum_type;      // Q7.28 row sum
   typedef logic signed [19:0] diff_type;      // prediction minus reference, Q8.12
   typedef logic signed [17:0] resp_type;      // cached B*u entry, Q6.12
   typedef logic signed [17:0] err_type;       // saturated tracking error
   typedef logic [34:0]        square_type;    // squared error, Q24
   typedef logic [33:0]        wcost_type;     // weight times toggle count
   typedef logic [35:0]        cost_type;      // total cost
   typedef logic [2:0]         vec_type;       // candidate switch vector

   // Configuration port types.
   typedef logic [2:0]  csr_index_type;
   typedef logic [31:0] csr_data_type;

   // Saturation limits of the error.
   localparam err_type ERR_MAX = 18'sh1FFFF;
   localparam err_type ERR_MIN = 18'sh20000;

   // Register indexes.
   localparam csr_index_type CSR_B_R0_LEG0     = 3'd0;
   localparam csr_index_type CSR_B_R0_LEG1     = 3'd1;
   localparam csr_index_type CSR_B_R0_LEG2     = 3'd2;
   localparam csr_index_type CSR_B_R1_LEG0     = 3'd3;
   localparam csr_index_type CSR_B_R1_LEG1     = 3'd4;
   localparam csr_index_type CSR_B_R1_LEG2     = 3'd5;
   localparam csr_index_type CSR_SWITCH_WEIGHT = 3'd6;

endpackage

@@ hdl/fcs_mpc_switch_select_unit.sv @@
// Top level of the predictive switch selector: an eight-stage pipelined cost evaluator.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------------
//   req     | in        | req_valid/stall    | meas0..1, ref0..1, a00..a11, prev_leg0..2
//   rsp     | out       | rsp_valid/stall    | leg0..2
//   csr     | in        | csr_valid/ready    | csr_index, csr_data
//
// One item is accepted per cycle unless the pipeline is stalled; its result passes through the
// stages of multiply, row sum, error, square, cost sum and a three-level compare tree.
// Reset clears all valid bits, the B registers, the weight and the cached responses.
// A stalled result freezes the whole pipeline and the input stall follows at once.
// A B write reaches the B registers first and then the cached responses; csr_ready is always high.
module fcs_mpc_switch_select_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fcs_pkg::sample_type    req_meas0,
   input  fcs_pkg::sample_type    req_meas1,
   input  fcs_pkg::sample_type    req_ref0,
   input  fcs_pkg::sample_type    req_ref1,
   input  fcs_pkg::coef_type      req_a00,
   input  fcs_pkg::coef_type      req_a01,
   input  fcs_pkg::coef_type      req_a10,
   input  fcs_pkg::coef_type      req_a11,
   input  logic                   req_prev_leg0,
   input  logic                   req_prev_leg1,
   input  logic                   req_prev_leg2,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_leg0,
   output logic                   rsp_leg1,
   output logic                   rsp_leg2,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  fcs_pkg::csr_index_type csr_index,
   input  fcs_pkg::csr_data_type  csr_data
);
   import fcs_pkg::*;

   // Configuration registers and cached responses.
   resp_type     b_ff [STATE_DIM][LEGS];
   logic [31:0]  weight_ff;
   resp_type     resp_ff [STATE_DIM][CANDIDATES];
   resp_type     resp_in [STATE_DIM][CANDIDATES];
   logic         csr_write;

   // Pipeline control.
   logic         adv;
   logic [6:0]   valid_ff;
   logic         rsp_valid_ff;

   // Stage 1: products.
   prod_type     prod_ff [4];
   sample_type   ref_s1_ff [STATE_DIM];
   vec_type      prev_s1_ff;

   // Stage 2: differences.
   psum_type     psum_in [STATE_DIM];
   diff_type     diff_ff [STATE_DIM];
   vec_type      prev_s2_ff;

   // Stage 3: saturated errors.
   logic signed [20:0] esum_in [STATE_DIM][CANDIDATES];
   err_type      err_in [STATE_DIM][CANDIDATES];
   err_type      err_ff [STATE_DIM][CANDIDATES];
   vec_type      prev_s3_ff;

   // Stage 4: squares and switching cost.
   logic signed [35:0] sqfull_in [STATE_DIM][CANDIDATES];
   square_type   sq_ff [STATE_DIM][CANDIDATES];
   wcost_type    wcost_in [CANDIDATES];
   wcost_type    wcost_ff [CANDIDATES];

   // Stage 5: total costs.
   cost_type     cost_ff [CANDIDATES];

   // Stages 6 to 8: compare tree.
   cost_type     t1_cost_ff [4];
   vec_type      t1_idx_ff [4];
   cost_type     t2_cost_ff [2];
   vec_type      t2_idx_ff [2];
   vec_type      best_ff;

   // The pipeline moves unless a finished item is held by the receiver.
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Configuration writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < STATE_DIM; r++) begin
            for (int l = 0; l < LEGS; l++) begin
               b_ff[r][l] <= '0;
            end
         end
         weight_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_B_R0_LEG0:     b_ff[0][0] <= resp_type'(signed'(csr_data[15:0]));
            CSR_B_R0_LEG1:     b_ff[0][1] <= resp_type'(signed'(csr_data[15:0]));
            CSR_B_R0_LEG2:     b_ff[0][2] <= resp_type'(signed'(csr_data[15:0]));
            CSR_B_R1_LEG0:     b_ff[1][0] <= resp_type'(signed'(csr_data[15:0]));
            CSR_B_R1_LEG1:     b_ff[1][1] <= resp_type'(signed'(csr_data[15:0]));
            CSR_B_R1_LEG2:     b_ff[1][2] <= resp_type'(signed'(csr_data[15:0]));
            CSR_SWITCH_WEIGHT: weight_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Response of each vector: sum of the B entries of the legs that are on.
   // Leg 0 is the top bit of the vector index.
   always_comb begin
      for (int r = 0; r < STATE_DIM; r++) begin
         for (int v = 0; v < CANDIDATES; v++) begin
            resp_in[r][v] = ((v & 4) != 0 ? b_ff[r][0] : '0)
                          + ((v & 2) != 0 ? b_ff[r][1] : '0)
                          + ((v & 1) != 0 ? b_ff[r][2] : '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < STATE_DIM; r++) begin
            for (int v = 0; v < CANDIDATES; v++) begin
               resp_ff[r][v] <= '0;
            end
         end
      end else begin
         resp_ff <= resp_in;
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff     <= {valid_ff[5:0], req_valid};
         rsp_valid_ff <= valid_ff[6];
      end
   end

   // Stage 2 row sums, shift with floor and reference subtraction.
   always_comb begin
      for (int r = 0; r < STATE_DIM; r++) begin
         psum_in[r] = {prod_ff[2*r][33], prod_ff[2*r]}
                    + {prod_ff[2*r+1][33], prod_ff[2*r+1]};
      end
   end

   // Stage 3 error per vector, saturated to 18 bits.
   always_comb begin
      for (int r = 0; r < STATE_DIM; r++) begin
         for (int v = 0; v < CANDIDATES; v++) begin
            esum_in[r][v] = {diff_ff[r][19], diff_ff[r]}
                          + {{3{resp_ff[r][v][17]}}, resp_ff[r][v]};
            if (!esum_in[r][v][20] && (esum_in[r][v][19:17] != 3'b000)) begin
               err_in[r][v] = ERR_MAX;
            end else if (esum_in[r][v][20] && (esum_in[r][v][19:17] != 3'b111)) begin
               err_in[r][v] = ERR_MIN;
            end else begin
               err_in[r][v] = esum_in[r][v][17:0];
            end
         end
      end
   end

   // Stage 4 squares and weight times the number of toggled legs.
   always_comb begin
      for (int r = 0; r < STATE_DIM; r++) begin
         for (int v = 0; v < CANDIDATES; v++) begin
            sqfull_in[r][v] = err_ff[r][v] * err_ff[r][v];
         end
      end
      for (int v = 0; v < CANDIDATES; v++) begin
         vec_type t;
         logic [1:0] n;
         t = prev_s3_ff ^ vec_type'(v);
         n = {1'b0, t[0]} + {1'b0, t[1]} + {1'b0, t[2]};
         case (n)
            2'd0:    wcost_in[v] = '0;
            2'd1:    wcost_in[v] = {2'b00, weight_ff};
            2'd2:    wcost_in[v] = {1'b0, weight_ff, 1'b0};
            2'd3:    wcost_in[v] = {2'b00, weight_ff} + {1'b0, weight_ff, 1'b0};
            default: wcost_in[v] = '0;
         endcase
      end
   end

   // Payload registers of all stages.
   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff[0]   <= req_a00 * req_meas0;
         prod_ff[1]   <= req_a01 * req_meas1;
         prod_ff[2]   <= req_a10 * req_meas0;
         prod_ff[3]   <= req_a11 * req_meas1;
         ref_s1_ff[0] <= req_ref0;
         ref_s1_ff[1] <= req_ref1;
         prev_s1_ff   <= {req_prev_leg0, req_prev_leg1, req_prev_leg2};

         for (int r = 0; r < STATE_DIM; r++) begin
            diff_ff[r] <= {psum_in[r][34], psum_in[r][34:16]}
                        - {{4{ref_s1_ff[r][15]}}, ref_s1_ff[r]};
         end
         prev_s2_ff <= prev_s1_ff;

         err_ff     <= err_in;
         prev_s3_ff <= prev_s2_ff;

         for (int r = 0; r < STATE_DIM; r++) begin
            for (int v = 0; v < CANDIDATES; v++) begin
               sq_ff[r][v] <= sqfull_in[r][v][34:0];
            end
         end
         wcost_ff <= wcost_in;

         for (int v = 0; v < CANDIDATES; v++) begin
            cost_ff[v] <= {1'b0, sq_ff[0][v]} + {1'b0, sq_ff[1][v]}
                        + {2'b00, wcost_ff[v]};
         end

         // Compare tree: the right entry wins only when strictly cheaper.
         for (int k = 0; k < 4; k++) begin
            if (cost_ff[2*k+1] < cost_ff[2*k]) begin
               t1_cost_ff[k] <= cost_ff[2*k+1];
               t1_idx_ff[k]  <= vec_type'(2*k+1);
            end else begin
               t1_cost_ff[k] <= cost_ff[2*k];
               t1_idx_ff[k]  <= vec_type'(2*k);
            end
         end
         for (int k = 0; k < 2; k++) begin
            if (t1_cost_ff[2*k+1] < t1_cost_ff[2*k]) begin
               t2_cost_ff[k] <= t1_cost_ff[2*k+1];
               t2_idx_ff[k]  <= t1_idx_ff[2*k+1];
            end else begin
               t2_cost_ff[k] <= t1_cost_ff[2*k];
               t2_idx_ff[k]  <= t1_idx_ff[2*k];
            end
         end
         best_ff <= (t2_cost_ff[1] < t2_cost_ff[0]) ? t2_idx_ff[1] : t2_idx_ff[0];
      end
   end

   // Result ports.
   assign rsp_valid = rsp_valid_ff;
   assign rsp_leg0  = best_ff[2];
   assign rsp_leg1  = best_ff[1];
   assign rsp_leg2  = best_ff[0];

`ifndef SYNTHESIS
   // An item in the first stage moves on when the pipeline advances.
   a_valid_moves: assert property (@(posedge clock) disable iff (reset)
      adv && valid_ff[0] |=> valid_ff[1])
      else $error("valid bit lost between stage one and two");

   // A frozen pipeline keeps every valid bit.
   a_frozen_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(valid_ff) && rsp_valid_ff)
      else $error("valid bits changed while frozen");

   // Input is stalled only while a result waits.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("input stalled without a waiting result");

   // Without a write in the previous cycle two sample cache entries match the B registers.
   a_cache_current: assert property (@(posedge clock) disable iff (reset)
      $past(!csr_write) |->
         resp_ff[0][7] == resp_type'(b_ff[0][0] + b_ff[0][1] + b_ff[0][2])
         && resp_ff[1][4] == b_ff[1][0])
      else $error("cached responses out of date");
`endif

endmodule

@@ bench/tb_fcs_mpc_switch_select_unit.sv @@
// Self-checking testbench for the predictive switch selector, with its own cost predictor.
module tb_fcs_mpc_switch_select_unit;
   import fcs_pkg::*;

   localparam int PIPE_LATENCY = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 160;
   localparam csr_index_type CSR_UNUSED = CSR_SWITCH_WEIGHT + 3'd1;
   localparam csr_index_type B_INDEX [STATE_DIM][LEGS] = '{
      '{CSR_B_R0_LEG0, CSR_B_R0_LEG1, CSR_B_R0_LEG2},
      '{CSR_B_R1_LEG0, CSR_B_R1_LEG1, CSR_B_R1_LEG2}
   };

   // One input item; prev holds leg 0 in bit 2 and leg 2 in bit 0.
   typedef struct {
      sample_type meas0;
      sample_type meas1;
      sample_type ref0;
      sample_type ref1;
      coef_type   a00;
      coef_type   a01;
      coef_type   a10;
      coef_type   a11;
      vec_type    prev;
   } req_item_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   sample_type    req_meas0, req_meas1, req_ref0, req_ref1;
   coef_type      req_a00, req_a01, req_a10, req_a11;
   logic          req_prev_leg0, req_prev_leg1, req_prev_leg2;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic          rsp_leg0, rsp_leg1, rsp_leg2;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   csr_data_type  csr_data;

   // Shadow copy of the register file used by the predictor.
   sample_type   b_shadow [STATE_DIM][LEGS] = '{default: '0};
   csr_data_type weight_shadow = '0;

   vec_type chosen_legs_q [$];
   int      mismatch_count = 0;
   bit      send_pacing = 1'b1;
   bit      recv_pacing = 1'b1;
   int      hold_count = 0;
   int      holds_started = 0;
   int      rsp_count = 0;
   int      rsp_count_seen = 0;
   int      rsp_wait_left = 0;

   fcs_mpc_switch_select_unit dut (.*);

   always #10 clock = ~clock;

   // Saturate a tracking error to the 18-bit signed range.
   function automatic longint clamp_error(longint value);
      if (value > longint'(ERR_MAX)) return longint'(ERR_MAX);
      if (value < longint'(ERR_MIN)) return longint'(ERR_MIN);
      return value;
   endfunction

   // Evaluate all eight switch vectors and return the cheapest one, lowest index on a tie.
   function automatic vec_type predict_switch_vector(req_item_type it);
      longint d0, d1, e0, e1, cost, best_cost;
      int     resp0, resp1;
      vec_type best;
      best = '0;
      best_cost = 0;
      d0 = ((longint'(it.a00) * longint'(it.meas0) + longint'(it.a01) * longint'(it.meas1))
            >>> 16) - longint'(it.ref0);
      d1 = ((longint'(it.a10) * longint'(it.meas0) + longint'(it.a11) * longint'(it.meas1))
            >>> 16) - longint'(it.ref1);
      for (int v = 0; v < CANDIDATES; v++) begin
         resp0 = 0;
         resp1 = 0;
         for (int l = 0; l < LEGS; l++) begin
            if (((v >> (LEGS - 1 - l)) & 1) != 0) begin
               resp0 += int'(b_shadow[0][l]);
               resp1 += int'(b_shadow[1][l]);
            end
         end
         e0 = clamp_error(d0 + resp0);
         e1 = clamp_error(d1 + resp1);
         cost = e0 * e0 + e1 * e1
              + longint'(weight_shadow) * $countones(vec_type'(v) ^ it.prev);
         if (v == 0 || cost < best_cost) begin
            best_cost = cost;
            best = vec_type'(v);
         end
      end
      return best;
   endfunction

   // Pick one of the corner values of a signed field of the given width.
   function automatic longint corner_value(int width);
      case ($urandom_range(0, 4))
         0: return -(longint'(1) << (width - 1));
         1: return (longint'(1) << (width - 1)) - 1;
         2: return 0;
         3: return -1;
         default: return 1;
      endcase
   endfunction

   function automatic req_item_type make_item(longint m0, longint m1, longint r0, longint r1,
                                              longint a00, longint a01, longint a10,
                                              longint a11, int prev);
      req_item_type it;
      it.meas0 = sample_type'(m0);
      it.meas1 = sample_type'(m1);
      it.ref0  = sample_type'(r0);
      it.ref1  = sample_type'(r1);
      it.a00   = coef_type'(a00);
      it.a01   = coef_type'(a01);
      it.a10   = coef_type'(a10);
      it.a11   = coef_type'(a11);
      it.prev  = vec_type'(prev);
      return it;
   endfunction

   // Mostly plant-like samples near the reference, some raw noise and some corner values.
   function automatic req_item_type random_item();
      req_item_type it;
      int        pick;
      int        m0, m1;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         it = make_item($urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 7));
      end else if (pick < 30) begin
         it = make_item(corner_value(16), corner_value(16), corner_value(16),
                        corner_value(16), corner_value(18), corner_value(18),
                        corner_value(18), corner_value(18), $urandom_range(0, 7));
      end else begin
         m0 = int'($urandom_range(0, 16384)) - 8192;
         m1 = int'($urandom_range(0, 16384)) - 8192;
         it = make_item(m0, m1,
                        m0 + int'($urandom_range(0, 6000)) - 3000,
                        m1 + int'($urandom_range(0, 6000)) - 3000,
                        65536 - int'($urandom_range(0, 8192)),
                        int'($urandom_range(0, 4096)) - 2048,
                        int'($urandom_range(0, 4096)) - 2048,
                        65536 - int'($urandom_range(0, 8192)),
                        $urandom_range(0, 7));
      end
      return it;
   endfunction

   // Offer one item after a random gap and record its expected switch vector on acceptance.
   // Entered and left at a falling edge.
   task automatic send_item(req_item_type it);
      int gap;
      gap = send_pacing ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_meas0 = it.meas0;
      req_meas1 = it.meas1;
      req_ref0  = it.ref0;
      req_ref1  = it.ref1;
      req_a00   = it.a00;
      req_a01   = it.a01;
      req_a10   = it.a10;
      req_a11   = it.a11;
      {req_prev_leg0, req_prev_leg1, req_prev_leg2} = it.prev;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      chosen_legs_q.push_back(predict_switch_vector(it));
      @(negedge clock);
   endtask

   // Write one register and mirror it in the shadow copy.
   task automatic write_csr(csr_index_type idx, csr_data_type data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SWITCH_WEIGHT) begin
         weight_shadow = data;
      end else if (idx < CSR_SWITCH_WEIGHT) begin
         b_shadow[int'(idx) / LEGS][int'(idx) % LEGS] = sample_type'(data[15:0]);
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_all(int b [STATE_DIM][LEGS], csr_data_type weight);
      for (int r = 0; r < STATE_DIM; r++) begin
         for (int l = 0; l < LEGS; l++) begin
            write_csr(B_INDEX[r][l], csr_data_type'(b[r][l]));
         end
      end
      write_csr(CSR_SWITCH_WEIGHT, weight);
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic settle_pipeline();
      req_valid = 1'b0;
      while (chosen_legs_q.size() != 0) @(negedge clock);
      repeat (PIPE_LATENCY + 2) @(negedge clock);
   endtask

   // Receiver stall: a fresh random wait after each result, or one long hold on request.
   always @(negedge clock) begin
      if (hold_count != holds_started) begin
         holds_started = hold_count;
         rsp_wait_left = HOLD_CYCLES;
      end else if (rsp_count != rsp_count_seen) begin
         rsp_wait_left = recv_pacing ? $urandom_range(0, 10) : 0;
      end
      rsp_count_seen = rsp_count;
      if (rsp_wait_left > 0) begin
         rsp_stall = 1'b1;
         rsp_wait_left--;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      vec_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (chosen_legs_q.size() == 0) begin
            $error("result with no item outstanding: legs %b%b%b", rsp_leg0, rsp_leg1,
                   rsp_leg2);
            mismatch_count++;
         end else begin
            want = chosen_legs_q.pop_front();
            if (rsp_leg0 !== want[2]) begin
               $error("leg0 expected %b actual %b", want[2], rsp_leg0);
               mismatch_count++;
            end
            if (rsp_leg1 !== want[1]) begin
               $error("leg1 expected %b actual %b", want[1], rsp_leg1);
               mismatch_count++;
            end
            if (rsp_leg2 !== want[0]) begin
               $error("leg2 expected %b actual %b", want[0], rsp_leg2);
               mismatch_count++;
            end
         end
      end
   end

   // With B and the weight at reset every vector costs the same, so vector zero wins.
   task automatic test_reset_state();
      send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 7));
      send_item(make_item(32767, 32767, 32767, 32767, 131071, 131071, 131071, 131071, 5));
      send_item(make_item(-32768, -32768, -32768, -32768, -131072, -131072, -131072,
                          -131072, 2));
      settle_pipeline();
   endtask

   // Field extremes and every previous switch state under an inverter-like B, then extreme B values.
   task automatic test_field_extremes();
      int b [STATE_DIM][LEGS];
      b = '{'{4096, -2048, -2048}, '{0, 3547, -3547}};
      write_all(b, 32'h0040_0000);
      for (int p = 0; p < CANDIDATES; p++) begin
         send_item(make_item(1000, -700, 900, -500, 65536, 0, 0, 65536, p));
      end
      send_item(make_item(32767, 32767, 0, 0, 131071, 131071, 131071, 131071, 0));
      send_item(make_item(32767, -32768, 0, 0, -131072, 131071, 131071, -131072, 7));
      send_item(make_item(-32768, -32768, 32767, -32768, -131072, -131072, -131072,
                          -131072, 3));
      send_item(make_item(0, 0, 32767, -32768, 0, 0, 0, 0, 4));
      settle_pipeline();
      b = '{'{-32768, -32768, -32768}, '{32767, 32767, 32767}};
      write_all(b, 32'hFFFF_FFFF);
      send_item(make_item(32767, -32768, -32768, 32767, 131071, 0, 0, 131071, 6));
      send_item(make_item(-32768, 32767, 32767, -32768, 131071, -131072, 131071, 0, 1));
      settle_pipeline();
   endtask

   // Ties, the unused register index, masked upper data bits and a weight-only write.
   task automatic test_special_cases();
      int b [STATE_DIM][LEGS];
      b = '{'{1000, 1000, 1000}, '{0, 0, 0}};
      write_all(b, 32'h0000_0000);
      // One-leg and two-leg vectors tie here; the lowest index must win.
      send_item(make_item(0, 0, 1500, 0, 0, 0, 0, 0, 0));
      settle_pipeline();
      write_csr(CSR_UNUSED, 32'hDEAD_BEEF);
      send_item(make_item(0, 0, 1500, 0, 0, 0, 0, 0, 6));
      settle_pipeline();
      write_csr(CSR_B_R0_LEG0, 32'hABCD_0000 | 32'(16'sd300));
      send_item(make_item(0, 0, 1500, 0, 0, 0, 0, 0, 0));
      settle_pipeline();
      write_csr(CSR_SWITCH_WEIGHT, 32'h0010_0000);
      send_item(make_item(0, 0, 1500, 0, 0, 0, 0, 0, 5));
      settle_pipeline();
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering.
   task automatic test_backpressure();
      int b [STATE_DIM][LEGS];
      b = '{'{3000, -1500, -1500}, '{0, 2600, -2600}};
      write_all(b, 32'h0002_0000);
      send_pacing = 1'b0;
      @(posedge clock);
      hold_count++;
      @(negedge clock);
      repeat (40) send_item(random_item());
      send_pacing = 1'b1;
      settle_pipeline();
   endtask

   // Random items under a sequence of register settings, including the extremes.
   task automatic test_random_phases();
      int b [STATE_DIM][LEGS];
      csr_data_type weight;
      int k;
      for (int phase = 0; phase < 8; phase++) begin
         for (int r = 0; r < STATE_DIM; r++) begin
            for (int l = 0; l < LEGS; l++) begin
               b[r][l] = int'($urandom_range(0, 8000)) - 4000;
            end
         end
         weight = '0;
         case (phase)
            1: weight = $urandom_range(0, 32'h0400_0000);
            2, 7: begin
               foreach (b[r, l]) b[r][l] = int'($urandom);
               weight = (phase == 2) ? $urandom : $urandom_range(0, 32'h0100_0000);
            end
            3: begin
               foreach (b[r, l]) b[r][l] = $urandom_range(0, 1) ? 32767 : -32768;
               weight = 32'hFFFF_FFFF;
            end
            4: begin
               b = '{default: 0};
               weight = $urandom_range(1, 32'h0100_0000);
            end
            5: begin
               k = $urandom_range(1000, 8000);
               b = '{'{k, -k / 2, -k / 2}, '{0, k * 7 / 8, -k * 7 / 8}};
               weight = $urandom_range(0, 32'h0100_0000);
            end
            6: begin
               // Equal columns make vectors with the same number of legs tie in their error cost.
               b[0] = '{b[0][0], b[0][0], b[0][0]};
               b[1] = '{b[1][0], b[1][0], b[1][0]};
               weight = $urandom_range(0, 1) ? '0 : $urandom_range(0, 32'h0010_0000);
            end
            default: ;
         endcase
         write_all(b, weight);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) begin
               send_pacing = ($urandom_range(0, 3) != 0);
               recv_pacing = ($urandom_range(0, 3) != 0);
            end
            send_item(random_item());
         end
         settle_pipeline();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      {req_meas0, req_meas1, req_ref0, req_ref1} = '0;
      {req_a00, req_a01, req_a10, req_a11} = '0;
      {req_prev_leg0, req_prev_leg1, req_prev_leg2} = '0;
      csr_valid = 1'b0;
      csr_index = CSR_B_R0_LEG0;
      csr_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_state();
      test_field_extremes();
      test_special_cases();
      test_backpressure();
      test_random_phases();
      settle_pipeline();
      if (mismatch_count == 0) begin
         $display("[fcs_mpc_switch_select_unit] OK");
      end else begin
         $display("[fcs_mpc_switch_select_unit] ERROR");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #5000000;
      $display("[fcs_mpc_switch_select_unit] ERROR");
      $finish;
   end

endmodule

@@ files.f @@
hdl/fcs_pkg.sv
hdl/fcs_mpc_switch_select_unit.sv
bench/tb_fcs_mpc_switch_select_unit.sv
